@@ rtl/cts_pkg.sv @@
// Shared types and constants for the cosine series core.
// Holds the divider request/response words and the term divisor function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cts_pkg;

  // Input field widths.
  localparam int XW   = 20;  // x_value
  localparam int TCW  = 5;   // term_count

  // Term magnitude: clamped to 2^31-1, so 31 bits.
  localparam int MAGW = 31;
  localparam int SUMW = 32;

  // Divisor (2i-1)(2i) for i up to 31 fits in 12 bits.
  localparam int KW       = 12;
  // Quotient bits produced by the divider and bits retired per cycle.
  localparam int QW       = 32;
  localparam int DIV_STEP = 8;
  localparam int DIV_CYC  = QW / DIV_STEP;
  localparam int DIV_CNTW = $clog2(DIV_CYC);

  typedef struct packed {
    logic          start;
    logic [KW-1:0] rem;   // upper numerator bits, already below den
    logic [QW-1:0] num;   // lower numerator bits, shifted in MSB first
    logic [KW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [QW-1:0] quo;
  } div_rsp_t;

  // Divisor of term i: (2i-1)(2i).
  function automatic logic [KW-1:0] term_div(input logic [TCW-1:0] i);
    logic [TCW:0] two_i;
    logic [TCW:0] two_i_m1;
    two_i    = {i, 1'b0};
    two_i_m1 = two_i - (TCW+1)'(1);
    // Widen both factors first so the product keeps all its bits.
    return KW'(two_i) * KW'(two_i_m1);
  endfunction

endpackage

`default_nettype wire

@@ rtl/cts_div.sv @@
// Iterative unsigned divider: 32 quotient bits, eight per cycle.
// Depends on cts_pkg for the request and response words.
`timescale 1ns / 1ps
`default_nettype none

module cts_div
  import cts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic                busy_r;
  logic                done_r;
  logic [DIV_CNTW-1:0] cnt_r;
  logic [KW-1:0]       rem_r;
  logic [KW-1:0]       den_r;
  logic [QW-1:0]       sh_r;

  logic [KW:0]         rem_t;
  logic [QW-1:0]       sh_t;

  // Restoring division, one bit per step.
  always_comb begin
    rem_t = {1'b0, rem_r};
    sh_t  = sh_r;
    for (int j = 0; j < DIV_STEP; j++) begin
      rem_t = {rem_t[KW-1:0], sh_t[QW-1]};
      sh_t  = {sh_t[QW-2:0], 1'b0};
      if (rem_t >= {1'b0, den_r}) begin
        rem_t   = rem_t - {1'b0, den_r};
        sh_t[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + DIV_CNTW'(1);
        if (cnt_r == DIV_CNTW'(DIV_CYC - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem;
      sh_r  <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= rem_t[KW-1:0];
      sh_r  <= sh_t;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = sh_r;

endmodule

`default_nettype wire

@@ rtl/cosine_taylor_series_core.sv @@
// Cosine series core: sums the first n terms of 1 - x^2/2! + x^4/4! - ...
// in fixed point. One shared multiplier and one iterative divider under a
// small sequencer. Depends on cts_pkg and cts_div.
//
// Usage
//   in_*  : one word per evaluation. in_tdata[19:0] = x_value (signed,
//           FRAC_BITS fraction bits), in_tdata[24:20] = term_count.
//           A term_count of zero counts as one, above MAX_TERMS as MAX_TERMS.
//   out_* : one word per input. out_tdata = series_sum (signed, FRAC_BITS
//           fraction bits), out_tuser = saturated (a term or the sum clamped).
// Timing
//   in_tready is high only while the sequencer is idle. The sequencer first
//   squares x and accumulates the first term; every further term then takes
//   the shared multiplier, a scale and range-check step, the divider (eight
//   quotient bits a cycle) and an accumulate step. A clamped term skips the
//   divider. The next word can be taken in the cycle that out_tvalid rises.
// Reset and stalls
//   rst_n (synchronous, active low) idles the sequencer and drops out_tvalid.
//   The result waits in an output register, so a new word is accepted while
//   it is held; should the next result finish before it is taken, the
//   sequencer holds in its done state until out_tready frees the register.
`timescale 1ns / 1ps
`default_nettype none

module cosine_taylor_series_core
  import cts_pkg::*;
#(
  parameter int MAX_TERMS = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [19:0] x_value, [24:20] term_count
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] series_sum
  output logic             out_tuser   // [0] saturated
);

  // Widths that follow from the fraction width.
  localparam int X2W = 2 * XW - FRAC_BITS;          // rounded x^2
  localparam int MB  = (X2W > XW) ? X2W : XW;       // shared multiplier B port
  localparam int PW  = MAGW + MB;                   // product
  localparam int NW  = PW + 1 - FRAC_BITS;          // scaled numerator
  localparam int CW  = (NW > KW + QW) ? NW : KW + QW; // compare width

  localparam logic [MAGW-1:0] MAG_MAX = '1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SQ    = 7'b0000010,
    S_ACC   = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_SCALE = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [XW-1:0]   ax_r, ax_nxt;
  logic [X2W-1:0]  x2_r, x2_nxt;
  logic [PW-1:0]   p_r, p_nxt;
  logic [MAGW-1:0] mag_r, mag_nxt;
  logic [SUMW-1:0] sum_r, sum_nxt;
  logic            sat_r, sat_nxt;
  logic [TCW-1:0]  i_r, i_nxt;
  logic [TCW-1:0]  last_r, last_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [SUMW-1:0] out_sum_r;
  logic            out_sat_r;

  logic            in_acc;
  logic            out_load;
  logic [XW-1:0]   x_in;
  logic [TCW-1:0]  tc_in;
  logic [TCW-1:0]  n_clamp;

  logic [MAGW-1:0] mul_a;
  logic [MB-1:0]   mul_b;
  logic [PW-1:0]   prod;

  logic [KW-1:0]   kdiv;
  logic [PW:0]     nsum;
  logic [CW-1:0]   ncw;
  logic [CW-1:0]   nlim;
  logic            scale_sat;

  logic [SUMW:0]   acc_s;
  logic [SUMW:0]   acc_term;

  div_req_t        div_req;
  div_rsp_t        div_rsp;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign x_in      = in_tdata[XW-1:0];
  assign tc_in     = in_tdata[XW +: TCW];

  // Clamp the term count to [1, MAX_TERMS].
  always_comb begin
    n_clamp = tc_in;
    if (tc_in == '0) begin
      n_clamp = TCW'(1);
    end else if ({1'b0, tc_in} > (TCW+1)'(MAX_TERMS)) begin
      n_clamp = TCW'(MAX_TERMS);
    end
  end

  // Shared multiplier: |x|*|x| while squaring, magnitude*x^2 per term.
  always_comb begin
    if (state_r == S_SQ) begin
      mul_a = MAGW'(ax_r);
      mul_b = MB'(ax_r);
    end else begin
      mul_a = mag_r;
      mul_b = MB'(x2_r);
    end
    prod = PW'(mul_a) * PW'(mul_b);
  end

  // Scale by 2^-FRAC_BITS with rounding, then range-check against k*2^31.
  assign kdiv      = term_div(i_r);
  assign nsum      = {1'b0, p_r} + ((PW+1)'(kdiv) << (FRAC_BITS - 1));
  assign ncw       = CW'(nsum >> FRAC_BITS);
  assign nlim      = CW'(kdiv) << MAGW;
  assign scale_sat = (ncw >= nlim);

  assign div_req.start = (state_r == S_SCALE) && !scale_sat;
  assign div_req.rem   = ncw[QW +: KW];
  assign div_req.num   = ncw[QW-1:0];
  assign div_req.den   = kdiv;

  cts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Accumulate with alternating sign; odd terms subtract.
  assign acc_term = (SUMW+1)'(mag_r);
  assign acc_s    = i_r[0] ? ({sum_r[SUMW-1], sum_r} - acc_term)
                           : ({sum_r[SUMW-1], sum_r} + acc_term);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    x2_nxt    = x2_r;
    p_nxt     = p_r;
    mag_nxt   = mag_r;
    sum_nxt   = sum_r;
    sat_nxt   = sat_r;
    i_nxt     = i_r;
    last_nxt  = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ax_nxt    = x_in[XW-1] ? (~x_in + XW'(1)) : x_in;
          last_nxt  = n_clamp - TCW'(1);
          mag_nxt   = MAGW'(1) << FRAC_BITS;
          sum_nxt   = '0;
          sat_nxt   = 1'b0;
          i_nxt     = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        x2_nxt    = X2W'((prod + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (!acc_s[SUMW] && acc_s[SUMW-1]) begin
          sum_nxt = {1'b0, {(SUMW-1){1'b1}}};
          sat_nxt = 1'b1;
        end else if (acc_s[SUMW] && !acc_s[SUMW-1]) begin
          sum_nxt = {1'b1, {(SUMW-1){1'b0}}};
          sat_nxt = 1'b1;
        end else begin
          sum_nxt = acc_s[SUMW-1:0];
        end
        if (i_r == last_r) begin
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_r + TCW'(1);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        p_nxt     = prod;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        if (scale_sat) begin
          mag_nxt   = MAG_MAX;
          sat_nxt   = 1'b1;
          state_nxt = S_ACC;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          mag_nxt   = div_rsp.quo[MAGW-1:0];
          state_nxt = S_ACC;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result until taken; drop valid once the receiver takes it.
  assign out_valid_nxt = (out_valid_r && !out_tready) || out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ax_r   <= ax_nxt;
    x2_r   <= x2_nxt;
    p_r    <= p_nxt;
    mag_r  <= mag_nxt;
    sum_r  <= sum_nxt;
    sat_r  <= sat_nxt;
    i_r    <= i_nxt;
    last_r <= last_nxt;
    if (out_load) begin
      out_sum_r <= sum_r;
      out_sat_r <= sat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sum_r;
  assign out_tuser  = out_sat_r;

  // An accepted word always starts with the square of x.
  a_accept_starts_square: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_SQ)
    else $error("accepted word did not start squaring");

  // The term index never runs past the clamped count.
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ACC |-> i_r <= last_r)
    else $error("term index beyond term count");

  // The divider only reports back while the sequencer waits on it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  // A started division has its partial remainder below the divisor.
  a_div_start_rem: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> div_req.rem < div_req.den)
    else $error("division started with remainder not below divisor");

endmodule

`default_nettype wire
